// ===== sv/ccc_pkg.sv =====
// Shared types, constants and the arctangent table for the circle contact unit.
`timescale 1ns / 1ps
package ccc_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam int CW = 28;
    localparam int ZW = 27;

    localparam logic signed [ZW-1:0] DEG180_Q16 = 27'sd11796480;
    localparam logic signed [ZW-1:0] DEG90_Q16  = 27'sd5898240;
    localparam logic signed [19:0]   DEG180_Q6  = 20'sd11520;
    localparam logic signed [19:0]   ANGLE_MAX  = 20'sd65535;
    localparam logic signed [19:0]   ANGLE_MIN  = -20'sd65536;

    typedef struct packed {
        logic                 hit;
        logic [11:0]          px;
        logic [11:0]          py;
        logic signed [15:0]   heading;
        logic                 fixed;
        logic signed [ZW-1:0] base;
    } side_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } vec_t;

    function automatic logic [21:0] atan_q16(input int i);
        logic [21:0] r;
        begin
            case (i)
                0:       r = 22'd2949120;
                1:       r = 22'd1740967;
                2:       r = 22'd919879;
                3:       r = 22'd466945;
                4:       r = 22'd234379;
                5:       r = 22'd117304;
                6:       r = 22'd58666;
                7:       r = 22'd29335;
                8:       r = 22'd14668;
                9:       r = 22'd7334;
                10:      r = 22'd3667;
                11:      r = 22'd1833;
                12:      r = 22'd917;
                13:      r = 22'd458;
                14:      r = 22'd229;
                15:      r = 22'd115;
                16:      r = 22'd57;
                17:      r = 22'd29;
                18:      r = 22'd14;
                19:      r = 22'd7;
                20:      r = 22'd4;
                21:      r = 22'd2;
                22:      r = 22'd1;
                default: r = 22'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== sv/circle_collision_contact_unit.sv =====
// Top level of the pipelined circle-circle contact and bounce angle unit.
// Input channel: in_valid/in_stall carry one circle pair per beat.
// Output channel: out_valid/out_stall carry collided, contact point and angle.
// Every input beat yields exactly one output beat, in order.
// Pipeline: three front stages, one register per CORDIC iteration
// and the output register.
// Throughput: one beat per cycle while out_stall does not hold the output; the whole pipeline advances together.
// When the output holds a beat and out_stall is high, the pipeline freezes
// and in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears every stage valid bit; no output beat until new input.
// No collision gives zero contact point and zero angle.
// Coincident centres give an atan2 of zero.
// The angle is saturated to the signed 17-bit range.
`timescale 1ns / 1ps
module circle_collision_contact_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        first_x,
    input  logic [15:0]        first_y,
    input  logic [11:0]        first_radius,
    input  logic signed [15:0] first_heading,
    input  logic [15:0]        second_x,
    input  logic [15:0]        second_y,
    input  logic [11:0]        second_radius,
    input  logic [11:0]        contact_margin,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               collided,
    output logic [11:0]        contact_x,
    output logic [11:0]        contact_y,
    output logic signed [16:0] contact_angle
);

    localparam int STEPS = (CORDIC_STEPS > ccc_pkg::ATAN_ENTRIES)
                         ? ccc_pkg::ATAN_ENTRIES : CORDIC_STEPS;

    logic           advance;
    logic           v_chain [STEPS+1];
    ccc_pkg::side_t s_chain [STEPS+1];
    ccc_pkg::vec_t  c_chain [STEPS+1];

    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;

    ccc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .in_valid       (in_valid),
        .first_x        (first_x),
        .first_y        (first_y),
        .first_radius   (first_radius),
        .first_heading  (first_heading),
        .second_x       (second_x),
        .second_y       (second_y),
        .second_radius  (second_radius),
        .contact_margin (contact_margin),
        .c_valid        (v_chain[0]),
        .c_side         (s_chain[0]),
        .c_vec          (c_chain[0])
    );

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cordic
        ccc_cordic_stage #(
            .STEP (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (v_chain[i]),
            .in_side   (s_chain[i]),
            .in_vec    (c_chain[i]),
            .out_valid (v_chain[i+1]),
            .out_side  (s_chain[i+1]),
            .out_vec   (c_chain[i+1])
        );
    end

    ccc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_valid      (v_chain[STEPS]),
        .in_side       (s_chain[STEPS]),
        .in_vec        (c_chain[STEPS]),
        .out_valid     (out_valid),
        .collided      (collided),
        .contact_x     (contact_x),
        .contact_y     (contact_y),
        .contact_angle (contact_angle)
    );

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !collided |-> contact_x == 12'd0 && contact_y == 12'd0
                                   && contact_angle == 17'sd0)
        else $error("miss beat carries non-zero contact data");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(collided)
            && $stable(contact_x) && $stable(contact_y) && $stable(contact_angle))
        else $error("stalled output beat changed");

    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

endmodule

// ===== sv/ccc_front.sv =====
// Front stages: offsets, squared distance, contact test and CORDIC set-up.
`timescale 1ns / 1ps
module ccc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  logic [15:0]         first_x,
    input  logic [15:0]         first_y,
    input  logic [11:0]         first_radius,
    input  logic signed [15:0]  first_heading,
    input  logic [15:0]         second_x,
    input  logic [15:0]         second_y,
    input  logic [11:0]         second_radius,
    input  logic [11:0]         contact_margin,
    output logic                c_valid,
    output ccc_pkg::side_t      c_side,
    output ccc_pkg::vec_t       c_vec
);

    logic                a_valid_reg;
    logic signed [16:0]  a_dx_reg;
    logic signed [16:0]  a_dy_reg;
    logic [13:0]         a_thr_reg;
    logic [11:0]         a_px_reg;
    logic [11:0]         a_py_reg;
    logic signed [15:0]  a_head_reg;

    logic                b_valid_reg;
    logic signed [16:0]  b_dx_reg;
    logic signed [16:0]  b_dy_reg;
    logic [33:0]         b_dx2_reg;
    logic [33:0]         b_dy2_reg;
    logic [27:0]         b_thr2_reg;
    logic [11:0]         b_px_reg;
    logic [11:0]         b_py_reg;
    logic signed [15:0]  b_head_reg;

    logic                c_valid_reg;
    ccc_pkg::side_t      c_side_reg;
    ccc_pkg::side_t      c_side_next;
    ccc_pkg::vec_t       c_vec_reg;
    ccc_pkg::vec_t       c_vec_next;

    logic signed [33:0]  dx2_s;
    logic signed [33:0]  dy2_s;
    logic [34:0]         dist2;
    logic signed [ccc_pkg::CW-1:0] x_ext;
    logic signed [ccc_pkg::CW-1:0] y_ext;

    assign dx2_s = a_dx_reg * a_dx_reg;
    assign dy2_s = a_dy_reg * a_dy_reg;
    assign dist2 = {1'b0, b_dx2_reg} + {1'b0, b_dy2_reg};
    assign x_ext = {{3{b_dx_reg[16]}}, b_dx_reg, 8'b0};
    assign y_ext = {{3{b_dy_reg[16]}}, b_dy_reg, 8'b0};

    always_comb
    begin
        c_side_next.hit     = dist2 <= {7'b0, b_thr2_reg};
        c_side_next.px      = b_px_reg;
        c_side_next.py      = b_py_reg;
        c_side_next.heading = b_head_reg;
        c_side_next.fixed   = 1'b0;
        c_side_next.base    = '0;
        c_vec_next.x        = x_ext;
        c_vec_next.y        = y_ext;
        c_vec_next.z        = '0;
        if (b_dy_reg == 17'sd0)
        begin
            c_side_next.fixed = 1'b1;
            c_side_next.base  = b_dx_reg[16] ? ccc_pkg::DEG180_Q16 : '0;
        end
        else if (b_dx_reg == 17'sd0)
        begin
            c_side_next.fixed = 1'b1;
            c_side_next.base  = b_dy_reg[16] ? -ccc_pkg::DEG90_Q16 : ccc_pkg::DEG90_Q16;
        end
        else if (b_dx_reg[16])
        begin
            c_side_next.base = b_dy_reg[16] ? -ccc_pkg::DEG180_Q16 : ccc_pkg::DEG180_Q16;
            c_vec_next.x     = -x_ext;
            c_vec_next.y     = -y_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_dx_reg   <= $signed({1'b0, first_x}) - $signed({1'b0, second_x});
            a_dy_reg   <= $signed({1'b0, first_y}) - $signed({1'b0, second_y});
            a_thr_reg  <= {2'b0, first_radius} + {2'b0, second_radius}
                        + {2'b0, contact_margin} + 14'd16;
            a_px_reg   <= first_x[15:4];
            a_py_reg   <= first_y[15:4];
            a_head_reg <= first_heading;

            b_dx_reg   <= a_dx_reg;
            b_dy_reg   <= a_dy_reg;
            b_dx2_reg  <= dx2_s;
            b_dy2_reg  <= dy2_s;
            b_thr2_reg <= a_thr_reg * a_thr_reg;
            b_px_reg   <= a_px_reg;
            b_py_reg   <= a_py_reg;
            b_head_reg <= a_head_reg;

            c_side_reg <= c_side_next;
            c_vec_reg  <= c_vec_next;
        end
    end

    assign c_valid = c_valid_reg;
    assign c_side  = c_side_reg;
    assign c_vec   = c_vec_reg;

endmodule

// ===== sv/ccc_cordic_stage.sv =====
// One registered vectoring CORDIC iteration.
`timescale 1ns / 1ps
module ccc_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic           in_valid,
    input  ccc_pkg::side_t in_side,
    input  ccc_pkg::vec_t  in_vec,
    output logic           out_valid,
    output ccc_pkg::side_t out_side,
    output ccc_pkg::vec_t  out_vec
);

    localparam logic signed [ccc_pkg::ZW-1:0] ANGLE =
        $signed({5'b0, ccc_pkg::atan_q16(STEP)});

    logic           valid_reg;
    ccc_pkg::side_t side_reg;
    ccc_pkg::vec_t  vec_reg;
    ccc_pkg::vec_t  vec_next;

    always_comb
    begin
        vec_next = in_vec;
        if (!in_side.fixed)
        begin
            if (in_vec.y > 0)
            begin
                vec_next.x = in_vec.x + (in_vec.y >>> STEP);
                vec_next.y = in_vec.y - (in_vec.x >>> STEP);
                vec_next.z = in_vec.z + ANGLE;
            end
            else
            begin
                vec_next.x = in_vec.x - (in_vec.y >>> STEP);
                vec_next.y = in_vec.y + (in_vec.x >>> STEP);
                vec_next.z = in_vec.z - ANGLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg <= in_side;
            vec_reg  <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_vec   = vec_reg;

endmodule

// ===== sv/ccc_back.sv =====
// Output stage: rounds the angle, forms the bounce heading and saturates.
`timescale 1ns / 1ps
module ccc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               in_valid,
    input  ccc_pkg::side_t     in_side,
    input  ccc_pkg::vec_t      in_vec,
    output logic               out_valid,
    output logic               collided,
    output logic [11:0]        contact_x,
    output logic [11:0]        contact_y,
    output logic signed [16:0] contact_angle
);

    logic                          valid_reg;
    logic                          hit_reg;
    logic [11:0]                   x_reg;
    logic [11:0]                   y_reg;
    logic signed [16:0]            ang_reg;
    logic signed [16:0]            ang_next;
    logic signed [ccc_pkg::ZW-1:0] full;
    logic signed [ccc_pkg::ZW-1:0] rounded;
    logic signed [16:0]            a6;
    logic signed [19:0]            sum;

    assign full    = in_side.base + in_vec.z;
    assign rounded = full + 27'sd512;
    assign a6      = rounded[26:10];
    assign sum     = ccc_pkg::DEG180_Q6 - $signed({{2{a6[16]}}, a6, 1'b0})
                   + $signed({{4{in_side.heading[15]}}, in_side.heading});

    always_comb
    begin
        if (sum > ccc_pkg::ANGLE_MAX)
            ang_next = ccc_pkg::ANGLE_MAX[16:0];
        else if (sum < ccc_pkg::ANGLE_MIN)
            ang_next = ccc_pkg::ANGLE_MIN[16:0];
        else
            ang_next = sum[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hit_reg <= in_side.hit;
            x_reg   <= in_side.hit ? in_side.px : 12'd0;
            y_reg   <= in_side.hit ? in_side.py : 12'd0;
            ang_reg <= in_side.hit ? ang_next : 17'sd0;
        end
    end

    assign out_valid     = valid_reg;
    assign collided      = hit_reg;
    assign contact_x     = x_reg;
    assign contact_y     = y_reg;
    assign contact_angle = ang_reg;

endmodule

// ===== verif/circle_collision_contact_unit_test.sv =====
// Self-checking testbench for the circle contact unit: directed, back-pressure and random pairs.
`timescale 1ns / 1ps
module circle_collision_contact_unit_test;

    localparam int STEPS = 16;
    localparam longint ROT180 = 11796480;
    localparam longint ROT90 = 5898240;
    localparam longint HALF_TURN_Q6 = 11520;
    localparam longint ANGLE_HI = 65535;
    localparam longint ANGLE_LO = -65536;
    localparam longint ARCTAN_Q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic [15:0]        x1;
        logic [15:0]        y1;
        logic [11:0]        r1;
        logic signed [15:0] heading;
        logic [15:0]        x2;
        logic [15:0]        y2;
        logic [11:0]        r2;
        logic [11:0]        margin;
    } pair_t;

    typedef struct packed {
        logic               hit;
        logic [11:0]        cx;
        logic [11:0]        cy;
        logic signed [16:0] angle;
    } contact_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [15:0]        first_x;
    logic [15:0]        first_y;
    logic [11:0]        first_radius;
    logic signed [15:0] first_heading;
    logic [15:0]        second_x;
    logic [15:0]        second_y;
    logic [11:0]        second_radius;
    logic [11:0]        contact_margin;
    logic               out_valid;
    logic               out_stall;
    logic               collided;
    logic [11:0]        contact_x;
    logic [11:0]        contact_y;
    logic signed [16:0] contact_angle;

    contact_t pending_contacts[$];
    int       mismatches = 0;
    int       stall_left = 0;
    bit       steady = 0;
    bit       hold_off = 0;

    circle_collision_contact_unit #(.CORDIC_STEPS(STEPS)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .first_x(first_x), .first_y(first_y), .first_radius(first_radius),
        .first_heading(first_heading), .second_x(second_x), .second_y(second_y),
        .second_radius(second_radius), .contact_margin(contact_margin),
        .out_valid(out_valid), .out_stall(out_stall),
        .collided(collided), .contact_x(contact_x), .contact_y(contact_y),
        .contact_angle(contact_angle)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic longint bearing_q16(longint dy, longint dx);
        longint x, y, z, t, base;
        begin
            if (dy == 0)
                return (dx < 0) ? ROT180 : 0;
            if (dx == 0)
                return (dy > 0) ? ROT90 : -ROT90;
            x = dx * 256;
            y = dy * 256;
            base = 0;
            if (x < 0)
            begin
                base = (y >= 0) ? ROT180 : -ROT180;
                x = -x;
                y = -y;
            end
            z = 0;
            for (int i = 0; i < STEPS && i < 24; i++)
            begin
                if (y > 0)
                begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    z += ARCTAN_Q16[i];
                end
                else
                begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    z -= ARCTAN_Q16[i];
                end
                x = t;
            end
            return base + z;
        end
    endfunction

    function automatic contact_t predict_contact(pair_t p);
        contact_t c;
        longint dx, dy, thr, a6, ang;
        begin
            dx = longint'(p.x1) - longint'(p.x2);
            dy = longint'(p.y1) - longint'(p.y2);
            thr = longint'(p.r1) + longint'(p.r2) + longint'(p.margin) + 16;
            c = '0;
            if (dx * dx + dy * dy <= thr * thr)
            begin
                a6 = (bearing_q16(dy, dx) + 512) >>> 10;
                ang = HALF_TURN_Q6 - 2 * a6 + longint'(p.heading);
                if (ang > ANGLE_HI)
                    ang = ANGLE_HI;
                if (ang < ANGLE_LO)
                    ang = ANGLE_LO;
                c.hit = 1'b1;
                c.cx = p.x1[15:4];
                c.cy = p.y1[15:4];
                c.angle = ang[16:0];
            end
            return c;
        end
    endfunction

    task automatic send_pair(pair_t p);
        int gap;
        begin
            gap = steady ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid       <= 1'b1;
            first_x        <= p.x1;
            first_y        <= p.y1;
            first_radius   <= p.r1;
            first_heading  <= p.heading;
            second_x       <= p.x2;
            second_y       <= p.y2;
            second_radius  <= p.r2;
            contact_margin <= p.margin;
            do @(posedge clk); while (in_stall);
            pending_contacts = {pending_contacts, predict_contact(p)};
        end
    endtask

    function automatic pair_t make_pair(logic [15:0] x1, logic [15:0] y1,
                                        logic [15:0] x2, logic [15:0] y2,
                                        logic [11:0] r1, logic [11:0] r2,
                                        logic [11:0] m, logic signed [15:0] h);
        make_pair = '{x1: x1, y1: y1, r1: r1, heading: h, x2: x2, y2: y2, r2: r2, margin: m};
    endfunction

    function automatic logic [15:0] offset_coord(logic [15:0] c, longint d);
        longint v;
        begin
            v = longint'(c) - d;
            if (v < 0 || v > 65535)
                v = longint'(c) + d;
            if (v < 0)
                v = 0;
            if (v > 65535)
                v = 65535;
            return v[15:0];
        end
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        longint thr, dx, dy;
        int kind;
        begin
            kind = $urandom_range(0, 9);
            p.x1 = 16'($urandom_range(0, 65535));
            p.y1 = 16'($urandom_range(0, 65535));
            p.x2 = 16'($urandom_range(0, 65535));
            p.y2 = 16'($urandom_range(0, 65535));
            p.r1 = 12'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                   : $urandom_range(0, 255));
            p.r2 = 12'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                   : $urandom_range(0, 255));
            p.margin = 12'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                       : $urandom_range(0, 63));
            p.heading = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 46080) - 23040);
            if (kind >= 2)
            begin
                thr = longint'(p.r1) + longint'(p.r2) + longint'(p.margin) + 16;
                dx = longint'($urandom_range(0, 2 * thr)) - thr;
                dy = longint'($urandom_range(0, 2 * thr)) - thr;
                if (kind == 2)
                    dx = 0;
                if (kind == 3)
                    dy = 0;
                if (kind == 4)
                begin
                    dx = ($urandom_range(0, 1) ? thr : -thr) + $urandom_range(0, 1);
                    dy = 0;
                end
                p.x2 = offset_coord(p.x1, dx);
                p.y2 = offset_coord(p.y1, dy);
            end
            return p;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_contacts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: hit=%0d x=%0d y=%0d angle=%0d",
                             collided, contact_x, contact_y, contact_angle);
            end
            else
            begin
                contact_t e;
                e = pending_contacts.pop_front();
                if (collided !== e.hit || contact_x !== e.cx || contact_y !== e.cy
                    || contact_angle !== e.angle)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp hit=%0d x=%0d y=%0d angle=%0d, got %0d %0d %0d %0d",
                                 e.hit, e.cx, e.cy, e.angle,
                                 collided, contact_x, contact_y, contact_angle);
                end
            end
            stall_left = steady ? 0 : $urandom_range(0, 5);
        end
        if (hold_off)
            out_stall <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic test_directed();
        begin
            // coincident centres, pure offsets, quadrants
            send_pair(make_pair(16'd1000, 16'd1000, 16'd1000, 16'd1000, 12'd16, 12'd16, 12'd0, 16'sd0));
            send_pair(make_pair(16'd1100, 16'd1000, 16'd1000, 16'd1000, 12'd64, 12'd64, 12'd0, 16'sd0));
            send_pair(make_pair(16'd900, 16'd1000, 16'd1000, 16'd1000, 12'd64, 12'd64, 12'd0, 16'sd0));
            send_pair(make_pair(16'd1000, 16'd1100, 16'd1000, 16'd1000, 12'd64, 12'd64, 12'd0, 16'sd0));
            send_pair(make_pair(16'd1000, 16'd900, 16'd1000, 16'd1000, 12'd64, 12'd64, 12'd0, 16'sd0));
            send_pair(make_pair(16'd1050, 16'd1030, 16'd1000, 16'd1000, 12'd64, 12'd64, 12'd5, 16'sd23040));
            send_pair(make_pair(16'd950, 16'd1030, 16'd1000, 16'd1000, 12'd64, 12'd64, 12'd5, -16'sd23040));
            send_pair(make_pair(16'd950, 16'd970, 16'd1000, 16'd1000, 12'd64, 12'd64, 12'd5, 16'sd100));
            send_pair(make_pair(16'd1050, 16'd970, 16'd1000, 16'd1000, 12'd64, 12'd64, 12'd5, -16'sd100));
            // exact threshold and one past it
            send_pair(make_pair(16'd1116, 16'd1000, 16'd1000, 16'd1000, 12'd50, 12'd50, 12'd0, 16'sd0));
            send_pair(make_pair(16'd1117, 16'd1000, 16'd1000, 16'd1000, 12'd50, 12'd50, 12'd0, 16'sd0));
            // far apart and close pairs, field extremes
            send_pair(make_pair(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 12'hFFF, 12'hFFF, 12'hFFF, 16'sh7FFF));
            send_pair(make_pair(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 12'd0, 12'd0, 12'd0, 16'sh8000));
            send_pair(make_pair(16'hFFFF, 16'hFFFF, 16'hFFF0, 16'hFFF0, 12'hFFF, 12'hFFF, 12'hFFF,
                                16'sh7FFF));
            send_pair(make_pair(16'd0, 16'd0, 16'd20, 16'd0, 12'hFFF, 12'hFFF, 12'hFFF, 16'sh8000));
            send_pair(make_pair(16'd0, 16'hFFFF, 16'd5, 16'hFFFA, 12'd0, 12'd0, 12'd0, -16'sd1));
        end
    endtask

    task automatic test_backpressure();
        begin
            fork
                begin
                    hold_off = 1;
                    repeat (120) @(posedge clk);
                    hold_off = 0;
                end
            join_none
            steady = 1;
            repeat (60) send_pair(random_pair());
            steady = 0;
        end
    endtask

    task automatic test_random();
        begin
            for (int n = 0; n < 1800; n++)
            begin
                if (n % 300 == 0)
                    steady = (n == 600);
                send_pair(random_pair());
            end
            steady = 0;
        end
    endtask

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        out_stall = 0;
        first_x = '0;
        first_y = '0;
        first_radius = '0;
        first_heading = '0;
        second_x = '0;
        second_y = '0;
        second_radius = '0;
        contact_margin = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random();
        in_valid <= 1'b0;
        while (pending_contacts.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
